// File: rtl/core/first_fit_free_list_allocator_core_defines.svh
// Assertion helpers shared by the allocator RTL.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define FFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// File: rtl/core/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

  localparam int HEAP_BYTES_DEF = 65536;
  localparam int MIN_SPLIT_DEF  = 24;
  localparam logic [63:0] GUARD_WORD = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [16:0] HEAP_MIN = 17'd104;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_METRIC = 2'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OOM     = 3'd1,
    ST_INVALID = 3'd2,
    ST_CORRUPT = 3'd3,
    ST_FATAL   = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_IDLE, S_P0, S_P1, S_P2,
    S_A_EV, S_A_NB0, S_A_NB1, S_A_LINK, S_A_H0, S_A_H1,
    S_F_HDR, S_F_HM, S_F_WALK, S_F_BRK, S_F_AC, S_F_AM,
    S_F_W0, S_F_W1, S_F_W2, S_M_EV, S_DONE
  } state_t;

  typedef struct packed {
    logic [16:0] heap;
    logic        nof;
    logic        init;
  } cfg_t;

  typedef struct packed {
    logic        we;
    logic [15:0] woff;
    logic [63:0] wdata;
    logic [15:0] roff;
  } mem_req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] grant_addr;
    logic [16:0] grant_size;
    logic [16:0] free_total;
    logic [16:0] largest_free;
    logic [12:0] free_count;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/first_fit_free_list_allocator_core.sv
`default_nettype none
// Channel  Direction  Contents
// in_      slave      tuser: req_type; tdata: req_size, req_addr
// out_     master     tuser: status; tdata: grant_addr .. free_count
// cfg_     APB slave  heap_bytes at 0x0, null_on_full at 0x4
//
// A request walks the free list in the header store, which has one write and
// one read port: each visited free block costs two reads, the wait for the
// registered read data and one decision (S_P0, S_P1, S_P2 and an evaluation
// state), and the closing states then finish the request. After reset S_INIT0
// and S_INIT1 lay down the initial free block; after a heap_bytes write the
// init flag is registered first. No request is taken meanwhile, and a new one
// only after the previous result is loaded. A stalled result sits in the output
// register while the next request is already accepted.
module first_fit_free_list_allocator_core #(
  parameter int HEAP_BYTES      = ffa_pkg::HEAP_BYTES_DEF,
  parameter int MIN_SPLIT_BYTES = ffa_pkg::MIN_SPLIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // req_size[16:0], req_addr[32:17], zero pad
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // grant_addr[15:0], grant_size[32:16], free_total[49:33], largest_free[66:50],
  // free_count[79:67]
  output logic [79:0]      out_tdata,
  output logic [2:0]       out_tuser,  // status[2:0]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import ffa_pkg::*;
  `include "first_fit_free_list_allocator_core_defines.svh"

  // Usable heap top: the parameter, capped by the 16-bit offset space.
  localparam int TOP   = ((HEAP_BYTES < 65536) ? HEAP_BYTES : 65536) / 8 * 8;
  localparam int DEPTH = TOP / 8;
  localparam logic [16:0] TOP17 = 17'(TOP);

  logic [16:0] heap_bytes_r, heap_bytes_nxt;
  logic [16:0] heap_eff_r, heap_eff_nxt;
  logic        nof_r, nof_nxt;
  logic        init_r;
  logic        cfg_wr;
  logic [16:0] h_round;
  cfg_t        cfg;
  res_t        res;
  mem_req_t    mreq;
  logic [63:0] mrdata;
  logic [17:0] alu_a, alu_b, alu_diff;
  logic        alu_lt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? {31'd0, nof_r} : {15'd0, heap_bytes_r};

  // A heap_bytes write rounds down to 8 and clamps into the supported range.
  assign h_round = {cfg_pwdata[16:3], 3'b000};

  always_comb begin
    heap_bytes_nxt = heap_bytes_r;
    heap_eff_nxt   = heap_eff_r;
    nof_nxt        = nof_r;
    if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        nof_nxt = cfg_pwdata[0];
      end else begin
        heap_bytes_nxt = cfg_pwdata[16:0];
        if (h_round < HEAP_MIN) begin
          heap_eff_nxt = HEAP_MIN;
        end else if (h_round > TOP17) begin
          heap_eff_nxt = TOP17;
        end else begin
          heap_eff_nxt = h_round;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_bytes_r <= 17'd65536;
      heap_eff_r   <= TOP17;
      nof_r        <= 1'b1;
    end else begin
      heap_bytes_r <= heap_bytes_nxt;
      heap_eff_r   <= heap_eff_nxt;
      nof_r        <= nof_nxt;
    end
  end

  // Re-initialization starts in the cycle after the heap size is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= 1'b0;
    end else begin
      init_r <= cfg_wr && !cfg_paddr[2];
    end
  end

  assign cfg.heap = heap_eff_r;
  assign cfg.nof  = nof_r;
  assign cfg.init = init_r;

  ffa_hdr_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (mrdata)
  );

  ffa_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .diff (alu_diff),
    .lt   (alu_lt)
  );

  ffa_seq #(.MIN_SPLIT_BYTES(MIN_SPLIT_BYTES)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_type   (in_tuser),
    .in_size   (in_tdata[16:0]),
    .in_addr   (in_tdata[32:17]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .mreq      (mreq),
    .mrdata    (mrdata),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_diff  (alu_diff),
    .alu_lt    (alu_lt)
  );

  assign out_tuser = res.status;
  assign out_tdata = {res.free_count, res.largest_free, res.free_total,
                      res.grant_size, res.grant_addr};

  // An accepted request keeps the block busy for at least the next cycle.
  `FFA_ASSERT_NXT(a_busy_after_req, in_tvalid && in_tready, !in_tready)
  // Failed requests never carry a grant.
  `FFA_ASSERT_IMP(a_no_grant_on_err, out_tvalid && (out_tuser != ST_OK), out_tdata[32:0] == 33'd0)
  // A heap size write blocks requests while the heap is rebuilt.
  `FFA_ASSERT_NXT(a_init_blocks, cfg.init, !in_tready)

endmodule
`default_nettype wire

// File: rtl/core/ffa_hdr_mem.sv
`default_nettype none
module ffa_hdr_mem #(
  parameter int DEPTH = ffa_pkg::HEAP_BYTES_DEF / 8
) (
  input  wire logic              clk,
  input  wire ffa_pkg::mem_req_t req,
  output logic [63:0]            rdata
);
  import ffa_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  // Header words, indexed by byte offset / 8.
  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.woff[IDX_W+2:3]] <= req.wdata;
    end
    rdata <= mem[req.roff[IDX_W+2:3]];
  end

endmodule
`default_nettype wire

// File: rtl/core/ffa_alu.sv
`default_nettype none
module ffa_alu (
  input  wire logic [17:0] op_a,
  input  wire logic [17:0] op_b,
  output logic      [17:0] diff,
  output logic             lt
);
  import ffa_pkg::*;

  // Shared subtract and magnitude compare.
  assign diff = op_a - op_b;
  assign lt   = (op_a < op_b);

endmodule
`default_nettype wire

// File: rtl/core/ffa_seq.sv
`default_nettype none
module ffa_seq #(
  parameter int MIN_SPLIT_BYTES = ffa_pkg::MIN_SPLIT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ffa_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_type,
  input  wire logic [16:0]       in_size,
  input  wire logic [15:0]       in_addr,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ffa_pkg::res_t          out_res,
  output ffa_pkg::mem_req_t      mreq,
  input  wire logic [63:0]       mrdata,
  output logic [17:0]            alu_a,
  output logic [17:0]            alu_b,
  input  wire logic [17:0]       alu_diff,
  input  wire logic              alu_lt
);
  import ffa_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] cur;
    logic [15:0] prev;
    logic        prev_v;
    logic [63:0] pn;
    logic [63:0] ps;
    logic [17:0] a;
    logic [15:0] hb;
    logic [15:0] start;
    logic [15:0] nnext;
    logic [15:0] after;
    logic [15:0] succ;
    logic [15:0] nb;
    logic [16:0] fsz;
    logic [16:0] nsize;
    logic [16:0] grant;
    logic [16:0] rem;
    logic        merged;
    logic        hupd;
    logic        succ_v;
    logic        after_v;
    logic [16:0] total;
    logic [16:0] big;
    logic [12:0] cnt;
    res_t        res;
  } dp_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  dp_t    dp_r, dp_nxt;
  logic [15:0] head_r, head_nxt;
  logic        head_v_r, head_v_nxt;
  logic        out_v_r, out_v_nxt;
  res_t        out_r, out_nxt;

  logic        accept, load_out;
  logic        pn_big, ps_big, end_x;
  logic [16:0] pn17, ps17;
  logic        a_fit, a_corrupt, a_split;
  logic        guard_ok, hdr_bad, bad_addr;
  logic [17:0] e2h, bend, e2a;
  logic        bend_bad, merged_w;
  status_t     oom_code;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !cfg.init;
  assign load_out = (state_r == S_DONE) && (!out_v_r || out_ready);
  assign oom_code = cfg.nof ? ST_OOM : ST_FATAL;

  assign pn_big = |dp_r.pn[63:17];
  assign ps_big = |dp_r.ps[63:17];
  assign pn17   = dp_r.pn[16:0];
  assign ps17   = dp_r.ps[16:0];
  // End of list: next not above the block just read, or no room for a header below the top.
  assign end_x  = pn_big || (pn17 <= {1'b0, dp_r.x}) ||
                  (({1'b0, pn17} + 18'd16) > {1'b0, cfg.heap});

  assign alu_a = (state_r == S_M_EV) ? {1'b0, dp_r.big} : {1'b0, ps17};
  assign alu_b = (state_r == S_M_EV) ? {1'b0, ps17} : dp_r.a;

  assign a_fit     = ps_big || !alu_lt;
  assign a_corrupt = ps_big || (dp_r.ps[2:0] != 3'd0) || (ps17 > cfg.heap);
  assign a_split   = (alu_diff[16:0] >= 17'(MIN_SPLIT_BYTES)) && (alu_diff[16:0] >= 17'd16);

  assign bad_addr = (in_addr[2:0] != 3'd0) || (in_addr < 16'd16) ||
                    ({1'b0, in_addr} > cfg.heap);
  assign guard_ok = (dp_r.ps == GUARD_WORD);
  assign e2h      = {2'b0, dp_r.hb} + 18'd16 + {1'b0, pn17};
  assign hdr_bad  = pn_big || (pn17 > cfg.heap) || (e2h > {1'b0, cfg.heap});
  assign bend     = {2'b0, dp_r.cur} + 18'd16 + {1'b0, ps17};
  assign bend_bad = ps_big || (bend > {2'b0, dp_r.hb});
  assign merged_w = (bend == {2'b0, dp_r.hb});
  assign e2a      = {2'b0, dp_r.start} + 18'd16 + {1'b0, dp_r.nsize};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT0: state_nxt = S_INIT1;
      S_INIT1: state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_type)
            REQ_ALLOC:  state_nxt = head_v_r ? S_P0 : S_DONE;
            REQ_FREE:   state_nxt = ((in_addr == 16'd0) || bad_addr) ? S_DONE : S_P0;
            REQ_METRIC: state_nxt = head_v_r ? S_P0 : S_DONE;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_P0: state_nxt = S_P1;
      S_P1: state_nxt = S_P2;
      S_P2: state_nxt = ret_r;
      S_A_EV: begin
        if (a_fit) begin
          state_nxt = a_corrupt ? S_DONE : (a_split ? S_A_NB0 : S_A_LINK);
        end else begin
          state_nxt = end_x ? S_DONE : S_P0;
        end
      end
      S_A_NB0:  state_nxt = S_A_NB1;
      S_A_NB1:  state_nxt = S_A_LINK;
      S_A_LINK: state_nxt = S_A_H0;
      S_A_H0:   state_nxt = S_A_H1;
      S_A_H1:   state_nxt = S_DONE;
      S_F_HDR: begin
        if (!guard_ok || hdr_bad) begin
          state_nxt = S_DONE;
        end else if (!head_v_r) begin
          state_nxt = S_F_W1;
        end else if (dp_r.hb < head_r) begin
          if (e2h > {2'b0, head_r}) begin
            state_nxt = S_DONE;
          end else if (e2h == {2'b0, head_r}) begin
            state_nxt = S_P0;
          end else begin
            state_nxt = S_F_W1;
          end
        end else begin
          state_nxt = S_P0;
        end
      end
      S_F_HM: state_nxt = S_F_W1;
      S_F_WALK: begin
        if (dp_r.cur == dp_r.hb) begin
          state_nxt = S_DONE;
        end else if (end_x || ({1'b0, dp_r.hb} < pn17)) begin
          state_nxt = S_F_BRK;
        end else begin
          state_nxt = S_P0;
        end
      end
      S_F_BRK: state_nxt = bend_bad ? S_DONE : (dp_r.after_v ? S_F_AC : S_F_W0);
      S_F_AC: begin
        if (e2a > {2'b0, dp_r.after}) begin
          state_nxt = S_DONE;
        end else if (e2a == {2'b0, dp_r.after}) begin
          state_nxt = S_P0;
        end else begin
          state_nxt = S_F_W0;
        end
      end
      S_F_AM: state_nxt = S_F_W0;
      S_F_W0: state_nxt = S_F_W1;
      S_F_W1: state_nxt = S_F_W2;
      S_F_W2: state_nxt = S_DONE;
      S_M_EV: state_nxt = end_x ? S_DONE : S_P0;
      S_DONE: state_nxt = load_out ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
    if (cfg.init) begin
      state_nxt = S_INIT0;
    end
  end

  // Datapath, header store requests and list head.
  always_comb begin
    dp_nxt     = dp_r;
    ret_nxt    = ret_r;
    head_nxt   = head_r;
    head_v_nxt = head_v_r;
    mreq.we    = 1'b0;
    mreq.woff  = 16'd0;
    mreq.wdata = 64'd0;
    mreq.roff  = dp_r.x;
    case (state_r)
      S_INIT0: begin
        mreq.we = 1'b1;
      end
      S_INIT1: begin
        mreq.we    = 1'b1;
        mreq.woff  = 16'd8;
        mreq.wdata = {47'd0, cfg.heap - 17'd16};
        head_nxt   = 16'd0;
        head_v_nxt = 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          dp_nxt.res    = '0;
          dp_nxt.a      = ({1'b0, in_size} + 18'd7) & ~18'd7;
          dp_nxt.x      = head_r;
          dp_nxt.cur    = head_r;
          dp_nxt.prev_v = 1'b0;
          dp_nxt.total  = 17'd0;
          dp_nxt.big    = 17'd0;
          dp_nxt.cnt    = 13'd0;
          dp_nxt.hb     = in_addr - 16'd16;
          case (in_type)
            REQ_ALLOC: begin
              ret_nxt = S_A_EV;
              if (!head_v_r) begin
                dp_nxt.res.status = oom_code;
              end
            end
            REQ_FREE: begin
              ret_nxt  = S_F_HDR;
              dp_nxt.x = in_addr - 16'd16;
              if ((in_addr != 16'd0) && bad_addr) begin
                dp_nxt.res.status = ST_INVALID;
              end
            end
            REQ_METRIC: ret_nxt = S_M_EV;
            default: ret_nxt = S_IDLE;
          endcase
        end
      end
      S_P1: begin
        mreq.roff = dp_r.x + 16'd8;
        dp_nxt.pn = mrdata;
      end
      S_P2: begin
        dp_nxt.ps = mrdata;
      end
      S_A_EV: begin
        if (a_fit) begin
          if (a_corrupt) begin
            dp_nxt.res.status = ST_CORRUPT;
          end else begin
            dp_nxt.grant  = a_split ? dp_r.a[16:0] : ps17;
            dp_nxt.rem    = alu_diff[16:0];
            dp_nxt.succ   = end_x ? 16'd0 : pn17[15:0];
            dp_nxt.succ_v = !end_x;
            dp_nxt.nb     = dp_r.cur + 16'd16 + dp_r.a[15:0];
          end
        end else if (end_x) begin
          dp_nxt.res.status = oom_code;
        end else begin
          dp_nxt.prev   = dp_r.cur;
          dp_nxt.prev_v = 1'b1;
          dp_nxt.cur    = pn17[15:0];
          dp_nxt.x      = pn17[15:0];
        end
      end
      S_A_NB0: begin
        mreq.we    = 1'b1;
        mreq.woff  = dp_r.nb;
        mreq.wdata = {48'd0, dp_r.succ};
      end
      S_A_NB1: begin
        mreq.we       = 1'b1;
        mreq.woff     = dp_r.nb + 16'd8;
        mreq.wdata    = {47'd0, dp_r.rem - 17'd16};
        dp_nxt.succ   = dp_r.nb;
        dp_nxt.succ_v = 1'b1;
      end
      S_A_LINK: begin
        if (dp_r.prev_v) begin
          mreq.we    = 1'b1;
          mreq.woff  = dp_r.prev;
          mreq.wdata = {48'd0, dp_r.succ_v ? dp_r.succ : 16'd0};
        end else begin
          head_nxt   = dp_r.succ_v ? dp_r.succ : 16'd0;
          head_v_nxt = dp_r.succ_v;
        end
      end
      S_A_H0: begin
        mreq.we    = 1'b1;
        mreq.woff  = dp_r.cur;
        mreq.wdata = {47'd0, dp_r.grant};
      end
      S_A_H1: begin
        mreq.we               = 1'b1;
        mreq.woff             = dp_r.cur + 16'd8;
        mreq.wdata            = GUARD_WORD;
        dp_nxt.res.grant_addr = dp_r.cur + 16'd16;
        dp_nxt.res.grant_size = dp_r.grant;
      end
      S_F_HDR: begin
        dp_nxt.fsz = pn17;
        if (!guard_ok) begin
          dp_nxt.res.status = ST_INVALID;
        end else if (hdr_bad) begin
          dp_nxt.res.status = ST_CORRUPT;
        end else if (!head_v_r) begin
          dp_nxt.start = dp_r.hb;
          dp_nxt.nnext = 16'd0;
          dp_nxt.nsize = pn17;
          dp_nxt.hupd  = 1'b1;
        end else if (dp_r.hb < head_r) begin
          dp_nxt.start = dp_r.hb;
          dp_nxt.nnext = head_r;
          dp_nxt.nsize = pn17;
          dp_nxt.hupd  = 1'b1;
          if (e2h > {2'b0, head_r}) begin
            dp_nxt.res.status = ST_CORRUPT;
          end else if (e2h == {2'b0, head_r}) begin
            dp_nxt.x = head_r;
            ret_nxt  = S_F_HM;
          end
        end else begin
          dp_nxt.hupd = 1'b0;
          dp_nxt.cur  = head_r;
          dp_nxt.x    = head_r;
          ret_nxt     = S_F_WALK;
        end
      end
      S_F_HM: begin
        dp_nxt.nsize = dp_r.fsz + 17'd16 + ps17;
        dp_nxt.nnext = end_x ? 16'd0 : pn17[15:0];
      end
      S_F_WALK: begin
        if (dp_r.cur == dp_r.hb) begin
          dp_nxt.res.status = ST_INVALID;
        end else if (end_x) begin
          dp_nxt.after_v = 1'b0;
        end else if ({1'b0, dp_r.hb} < pn17) begin
          dp_nxt.after   = pn17[15:0];
          dp_nxt.after_v = 1'b1;
        end else begin
          dp_nxt.cur = pn17[15:0];
          dp_nxt.x   = pn17[15:0];
        end
      end
      S_F_BRK: begin
        if (bend_bad) begin
          dp_nxt.res.status = ST_CORRUPT;
        end
        dp_nxt.merged = merged_w;
        dp_nxt.start  = merged_w ? dp_r.cur : dp_r.hb;
        dp_nxt.nsize  = merged_w ? (ps17 + 17'd16 + dp_r.fsz) : dp_r.fsz;
        dp_nxt.nnext  = 16'd0;
      end
      S_F_AC: begin
        dp_nxt.nnext = dp_r.after;
        if (e2a > {2'b0, dp_r.after}) begin
          dp_nxt.res.status = ST_CORRUPT;
        end else if (e2a == {2'b0, dp_r.after}) begin
          dp_nxt.x = dp_r.after;
          ret_nxt  = S_F_AM;
        end
      end
      S_F_AM: begin
        dp_nxt.nsize = dp_r.nsize + 17'd16 + ps17;
        dp_nxt.nnext = end_x ? 16'd0 : pn17[15:0];
      end
      S_F_W0: begin
        // A merged block still loses its guard so a second free is caught.
        mreq.we    = 1'b1;
        mreq.woff  = dp_r.merged ? (dp_r.hb + 16'd8) : dp_r.cur;
        mreq.wdata = dp_r.merged ? 64'd0 : {48'd0, dp_r.hb};
      end
      S_F_W1: begin
        mreq.we    = 1'b1;
        mreq.woff  = dp_r.start;
        mreq.wdata = {48'd0, dp_r.nnext};
      end
      S_F_W2: begin
        mreq.we    = 1'b1;
        mreq.woff  = dp_r.start + 16'd8;
        mreq.wdata = {47'd0, dp_r.nsize};
        if (dp_r.hupd) begin
          head_nxt   = dp_r.start;
          head_v_nxt = 1'b1;
        end
      end
      S_M_EV: begin
        dp_nxt.cnt   = dp_r.cnt + 13'd1;
        dp_nxt.total = dp_r.total + ps17;
        if (alu_lt) begin
          dp_nxt.big = ps17;
        end
        if (end_x) begin
          dp_nxt.res.free_total   = dp_r.total + ps17;
          dp_nxt.res.largest_free = alu_lt ? ps17 : dp_r.big;
          dp_nxt.res.free_count   = dp_r.cnt + 13'd1;
        end else begin
          dp_nxt.x = pn17[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_comb begin
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (load_out) begin
      out_v_nxt = 1'b1;
      out_nxt   = dp_r.res;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT0;
      ret_r    <= S_IDLE;
      head_r   <= 16'd0;
      head_v_r <= 1'b1;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      head_r   <= head_nxt;
      head_v_r <= head_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dp_r  <= dp_nxt;
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// File: sim/tb_first_fit_free_list_allocator_core.sv
`timescale 1ns / 100ps
`default_nettype none

// Testbench for the first-fit allocator core. An initial block builds the
// requests phase by phase, predicts every result with its own model of the
// header store and queues both. A clocked driver presents the requests with
// random gaps. A clocked monitor drains results under random back pressure
// and compares each one with the oldest predicted result.
module tb_first_fit_free_list_allocator_core;
  import ffa_pkg::*;

  localparam int STORE_WORDS = HEAP_BYTES_DEF / 8;
  localparam int LIMIT_CYCLES = 12000000;

  typedef struct {
    logic [1:0]  kind;
    logic [16:0] size;
    logic [15:0] addr;
  } alloc_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  first_fit_free_list_allocator_core DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the heap: header words, which words have been written,
  // the list head and the active configuration.
  logic [63:0] hdr_words [STORE_WORDS];
  bit word_written [STORE_WORDS];
  int unsigned list_head;
  bit list_nonempty;
  int unsigned heap_size;
  bit null_on_full_q;

  // Payload offsets currently granted, and offsets that were freed.
  int unsigned live_blocks[$];
  int unsigned freed_blocks[$];

  alloc_req_t pending_reqs[$];
  res_t expected_results[$];

  int mismatches = 0;
  int results_seen = 0;

  function automatic logic [63:0] hdr_read(int unsigned off);
    return ((off >> 3) < STORE_WORDS) ? hdr_words[off >> 3] : 64'd0;
  endfunction

  function automatic void hdr_write(int unsigned off, logic [63:0] v);
    if ((off >> 3) < STORE_WORDS) begin
      hdr_words[off >> 3] = v;
      word_written[off >> 3] = 1'b1;
    end
  endfunction

  // A next pointer that does not move forward or would not fit ends the list.
  function automatic bit list_ends(int unsigned cur, logic [63:0] nxt);
    return (nxt <= 64'(cur)) || (nxt + 64'd16 > 64'(heap_size));
  endfunction

  function automatic void heap_reinit(logic [16:0] req_bytes);
    int unsigned h;
    h = req_bytes & ~32'd7;
    if (h < 104) h = 104;
    if (h > 65536) h = 65536;
    heap_size = h;
    for (int i = 0; i < STORE_WORDS; i++) begin
      hdr_words[i] = '0;
      word_written[i] = 1'b0;
    end
    hdr_write(0, 64'd0);
    hdr_write(8, 64'(h - 16));
    list_head = 0;
    list_nonempty = 1'b1;
    live_blocks.delete();
    freed_blocks.delete();
  endfunction

  function automatic res_t predict_alloc(int unsigned req);
    res_t r;
    int unsigned want, cur, prev, succ, nb;
    bit prev_ok, succ_ok, last;
    logic [63:0] nxt, sz, rem, grant;
    r = '0;
    want = (req + 7) & ~32'd7;
    cur = list_head;
    prev = 0;
    prev_ok = 1'b0;
    if (list_nonempty) begin
      forever begin
        nxt = hdr_read(cur);
        sz = hdr_read(cur + 8);
        last = list_ends(cur, nxt);
        if (sz >= 64'(want)) begin
          if (sz[2:0] != 3'd0 || sz > 64'(heap_size)) begin
            r.status = ST_CORRUPT;
            return r;
          end
          rem = sz - 64'(want);
          grant = 64'(want);
          succ = last ? 0 : int'(nxt);
          succ_ok = !last;
          // Split only when the remainder is worth a block of its own.
          if (rem < 64'(MIN_SPLIT_DEF) || rem < 64'd16) begin
            grant = sz;
          end else begin
            nb = cur + 16 + want;
            hdr_write(nb, 64'(succ));
            hdr_write(nb + 8, rem - 64'd16);
            succ = nb;
            succ_ok = 1'b1;
          end
          if (prev_ok) begin
            hdr_write(prev, succ_ok ? 64'(succ) : 64'd0);
          end else begin
            list_nonempty = succ_ok;
            list_head = succ_ok ? succ : 0;
          end
          hdr_write(cur, grant);
          hdr_write(cur + 8, GUARD_WORD);
          r.status = ST_OK;
          r.grant_addr = 16'(cur + 16);
          r.grant_size = grant[16:0];
          return r;
        end
        if (last) break;
        prev = cur;
        prev_ok = 1'b1;
        cur = int'(nxt);
      end
    end
    r.status = null_on_full_q ? ST_OOM : ST_FATAL;
    return r;
  endfunction

  function automatic res_t predict_release(int unsigned addr);
    res_t r;
    int unsigned hb, cur, start, af;
    logic [63:0] sz, nsize, nnext, after, bend, end2, nxt;
    bit after_ok, merged;
    r = '0;
    nnext = 0;
    after = 0;
    after_ok = 1'b0;
    if (addr == 0) return r;
    if (addr[2:0] != 3'd0 || addr < 16 || addr > heap_size ||
        hdr_read(addr - 8) != GUARD_WORD) begin
      r.status = ST_INVALID;
      return r;
    end
    hb = addr - 16;
    sz = hdr_read(hb);
    if (sz > 64'(heap_size) || 64'(hb) + 64'd16 + sz > 64'(heap_size)) begin
      r.status = ST_CORRUPT;
      return r;
    end
    // The block goes in front of the current head, or the list is empty.
    if (!list_nonempty || hb < list_head) begin
      nsize = sz;
      if (list_nonempty) begin
        end2 = 64'(hb) + 64'd16 + sz;
        if (end2 > 64'(list_head)) begin
          r.status = ST_CORRUPT;
          return r;
        end
        if (end2 == 64'(list_head)) begin
          nsize = sz + 64'd16 + hdr_read(list_head + 8);
          nnext = hdr_read(list_head);
          if (list_ends(list_head, nnext)) nnext = 0;
        end else begin
          nnext = 64'(list_head);
        end
      end
      hdr_write(hb, nnext);
      hdr_write(hb + 8, nsize);
      list_head = hb;
      list_nonempty = 1'b1;
      return r;
    end
    // Walk to the last free block below the one being released.
    cur = list_head;
    forever begin
      nxt = hdr_read(cur);
      if (cur == hb) begin
        r.status = ST_INVALID;
        return r;
      end
      if (list_ends(cur, nxt)) break;
      if (64'(hb) < nxt) begin
        after = nxt;
        after_ok = 1'b1;
        break;
      end
      cur = int'(nxt);
    end
    bend = 64'(cur) + 64'd16 + hdr_read(cur + 8);
    if (bend > 64'(hb)) begin
      r.status = ST_CORRUPT;
      return r;
    end
    merged = (bend == 64'(hb));
    start = merged ? cur : hb;
    nsize = merged ? hdr_read(cur + 8) + 64'd16 + sz : sz;
    if (after_ok) begin
      end2 = 64'(start) + 64'd16 + nsize;
      if (end2 > after) begin
        r.status = ST_CORRUPT;
        return r;
      end
      if (end2 == after) begin
        af = int'(after);
        nsize += 64'd16 + hdr_read(af + 8);
        nnext = hdr_read(af);
        if (list_ends(af, nnext)) nnext = 0;
      end else begin
        nnext = after;
      end
    end
    // The guard is cleared even when the block merges into its predecessor.
    if (merged) hdr_write(hb + 8, 64'd0);
    else hdr_write(cur, 64'(hb));
    hdr_write(start, nnext);
    hdr_write(start + 8, nsize);
    return r;
  endfunction

  function automatic res_t predict_metrics();
    res_t r;
    int unsigned cur;
    logic [63:0] nxt, sz, total, big, count;
    r = '0;
    total = 0;
    big = 0;
    count = 0;
    cur = list_head;
    if (list_nonempty) begin
      forever begin
        nxt = hdr_read(cur);
        sz = hdr_read(cur + 8);
        count++;
        total += sz;
        if (sz > big) big = sz;
        if (list_ends(cur, nxt)) break;
        cur = int'(nxt);
      end
    end
    r.free_total = total[16:0];
    r.largest_free = big[16:0];
    r.free_count = count[12:0];
    return r;
  endfunction

  // Predicts one request, keeps the bookkeeping of granted blocks and
  // queues the request together with its expected result.
  task automatic issue(logic [1:0] kind, logic [16:0] size, logic [15:0] addr);
    alloc_req_t q;
    res_t r;
    q.kind = kind;
    q.size = size;
    q.addr = addr;
    r = '0;
    case (kind)
      REQ_ALLOC: begin
        r = predict_alloc(size);
        if (r.status == ST_OK) live_blocks.push_back(r.grant_addr);
      end
      REQ_FREE: begin
        r = predict_release(addr);
        if (r.status == ST_OK && addr != 0) begin
          foreach (live_blocks[i]) begin
            if (live_blocks[i] == addr) begin
              live_blocks.delete(i);
              break;
            end
          end
          freed_blocks.push_back(addr);
        end
      end
      REQ_METRIC: r = predict_metrics();
      default: r = '0;
    endcase
    pending_reqs.push_back(q);
    expected_results.push_back(r);
  endtask

  // A free address that never reads a header word the core has not written.
  function automatic logic [15:0] noise_addr();
    int unsigned a;
    a = $urandom_range(65535, 0);
    if ($urandom_range(1, 0)) a = a & ~32'd7;
    if (a[2:0] == 3'd0 && a >= 16 && a <= heap_size && !word_written[(a - 8) >> 3]) begin
      if (freed_blocks.size() > 0) begin
        a = freed_blocks[$urandom_range(freed_blocks.size() - 1, 0)];
      end else begin
        a = a | 32'd1;
      end
    end
    return 16'(a);
  endfunction

  function automatic logic [16:0] random_size();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 65) return 17'($urandom_range(64, 0));
    if (pick < 88) return 17'($urandom_range(512, 0));
    if (pick < 98) return 17'($urandom_range(heap_size / 2, 0));
    return 17'($urandom_range(65536, 0));
  endfunction

  task automatic random_phase(int count);
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99, 0);
      if (live_blocks.size() == 0 && pick < 85) begin
        issue(REQ_ALLOC, random_size(), 16'($urandom));
      end else if (pick < 45) begin
        issue(REQ_ALLOC, random_size(), 16'($urandom));
      end else if (pick < 85) begin
        issue(REQ_FREE, 17'($urandom),
              16'(live_blocks[$urandom_range(live_blocks.size() - 1, 0)]));
      end else if (pick < 91) begin
        issue(REQ_METRIC, 17'($urandom), 16'($urandom));
      end else if (pick < 93) begin
        issue(2'd3, 17'($urandom), 16'($urandom));
      end else if (pick < 94) begin
        issue(REQ_FREE, 17'($urandom), 16'd0);
      end else begin
        issue(REQ_FREE, 17'($urandom), noise_addr());
      end
    end
  endtask

  // Waits until the core has returned every predicted result.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // APB write: a setup cycle, then an access cycle that commits the register.
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == 3'h0) heap_reinit(data[16:0]);
    else null_on_full_q = data[0];
  endtask

  task automatic phase_with(logic [31:0] heap_val, bit nof, int count);
    drain();
    reg_write(3'h0, heap_val);
    reg_write(3'h4, {31'd0, nof});
    random_phase(count);
  endtask

  // Request sender with random gaps. tvalid and tdata are assigned once per
  // edge so that a back-to-back request never drops tvalid.
  int send_gap = 0;
  always @(posedge clk) begin
    alloc_req_t q;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        q = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= q.kind;
        in_tdata <= {7'd0, q.addr, q.size};
        send_gap <= ($urandom_range(9, 0) < 6) ? 0 :
                    ($urandom_range(19, 0) == 0) ? $urandom_range(200, 20) :
                    $urandom_range(4, 1);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long hold-off of the result channel, counted here, once results flow,
  // so that the core fills up and stops taking requests.
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!hold_done && results_seen == 300) begin
      hold_cycles <= 3000;
      hold_done <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Result checker with random back pressure.
  int stall_left = 0;
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser);
        got.grant_addr = out_tdata[15:0];
        got.grant_size = out_tdata[32:16];
        got.free_total = out_tdata[49:33];
        got.largest_free = out_tdata[66:50];
        got.free_count = out_tdata[79:67];
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d addr %0d size %0d", got.status,
                     got.grant_addr, got.grant_size);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected st %0d ga %0d gs %0d ft %0d lf %0d fc %0d, got st %0d ga %0d gs %0d ft %0d lf %0d fc %0d",
                       results_seen, want.status, want.grant_addr, want.grant_size,
                       want.free_total, want.largest_free, want.free_count,
                       got.status, got.grant_addr, got.grant_size,
                       got.free_total, got.largest_free, got.free_count);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        out_tready <= 1'b0;
      end else if ($urandom_range(9, 0) < 2) begin
        stall_left <= ($urandom_range(14, 0) == 0) ? $urandom_range(150, 20) :
                      $urandom_range(3, 0);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_first_fit_free_list_allocator_core: errors");
      $finish;
    end
  end

  initial begin
    int unsigned a0;
    int unsigned a1;
    heap_reinit(17'd65536);
    null_on_full_q = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests on the reset heap: empty and full sizes, every
    // request kind, bad addresses and a double free.
    issue(REQ_METRIC, 17'd0, 16'd0);
    issue(REQ_ALLOC, 17'd0, 16'hFFFF);
    issue(REQ_ALLOC, 17'd1, 16'd0);
    issue(REQ_ALLOC, 17'd8, 16'd0);
    issue(REQ_ALLOC, 17'd65536, 16'd0);
    issue(REQ_ALLOC, 17'd100, 16'd0);
    a0 = live_blocks[1];
    a1 = live_blocks[3];
    issue(REQ_FREE, 17'h1FFFF, 16'd0);
    issue(REQ_FREE, 17'd0, 16'd3);
    issue(REQ_FREE, 17'd0, 16'd8);
    issue(REQ_FREE, 17'd0, 16'(a0));
    issue(REQ_FREE, 17'd0, 16'(a0));
    issue(REQ_FREE, 17'd0, 16'(a1));
    issue(2'd3, 17'h1FFFF, 16'hFFFF);
    issue(REQ_METRIC, 17'd0, 16'd0);

    // Smallest heap: the tail block goes whole and the list runs empty,
    // first with the plain and then with the fatal out-of-memory status.
    drain();
    reg_write(3'h0, 32'd0);
    issue(REQ_ALLOC, 17'd88, 16'd0);
    issue(REQ_ALLOC, 17'd0, 16'd0);
    issue(REQ_METRIC, 17'd0, 16'd0);
    drain();
    reg_write(3'h4, 32'd0);
    issue(REQ_ALLOC, 17'd0, 16'd0);
    issue(REQ_FREE, 17'd0, 16'd16);
    issue(REQ_ALLOC, 17'd60, 16'd0);
    issue(REQ_METRIC, 17'd0, 16'd0);

    random_phase(150);
    phase_with(32'd104, 1'b1, 150);
    phase_with(32'd650, 1'b0, 200);
    phase_with(32'd2048, 1'b1, 250);
    phase_with(32'($urandom_range(8192, 104)), 1'b0, 200);
    phase_with(32'h1FFFF, 1'b1, 150);
    phase_with(32'd65536, 1'b0, 120);
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_first_fit_free_list_allocator_core: clean");
    end else begin
      $display("tb_first_fit_free_list_allocator_core: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
